[rtl/core/well512_random_generator_top_defines.svh]
// Assertion macros shared by the WELL512a generator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef WELL512_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define WELL512_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Same-cycle property, checked outside reset
`define WRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent now, consequent in the next cycle
`define WRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wrg_pkg.sv]
// Package for the WELL512a generator: widths, constants, codes, state type
// and the recurrence mixing functions. No dependencies.
`timescale 1ns / 1ps

package wrg_pkg;

  localparam int WordW     = 32;
  localparam int PoolDepth = 16;
  localparam int PoolAw    = $clog2(PoolDepth);
  localparam int SpanW     = WordW + 1;
  localparam int ProdW     = 2 * WordW;

  localparam logic [WordW-1:0] SeedReset  = 32'h5EE3_9C34;
  localparam logic [WordW-1:0] SeedMix    = 32'hF68A_9FC1;
  localparam logic [WordW-1:0] ChainMul   = 32'h6C07_8965;
  localparam logic [WordW-1:0] TemperMask = 32'hDA44_2D20;
  localparam logic [WordW-1:0] SignFlip   = 32'h8000_0000;

  // Tap offsets into the circular pool, relative to the position
  localparam logic [PoolAw-1:0] OffTapA  = PoolAw'(13);
  localparam logic [PoolAw-1:0] OffTapB  = PoolAw'(9);
  localparam logic [PoolAw-1:0] OffPrev  = PoolAw'(15);
  localparam logic [PoolAw-1:0] PoolLast = PoolAw'(PoolDepth - 1);

  typedef enum logic [1:0] {
    REQ_RAW    = 2'd0,
    REQ_RANGE  = 2'd1,
    REQ_RESEED = 2'd2,
    REQ_LOAD   = 2'd3
  } wrg_req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_WR,
    ST_MUL,
    ST_ADD,
    ST_OUT,
    ST_FFIRST,
    ST_FMUL,
    ST_FWR
  } wrg_state_e;

  // Request to the shared multiplier
  typedef struct packed {
    logic             en;
    logic [WordW-1:0] a;
    logic [SpanW-1:0] b;
  } wrg_mul_req_t;

  function automatic logic [WordW-1:0] well_b(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] c);
    return a ^ c ^ (a << 16) ^ (c << 15);
  endfunction

  function automatic logic [WordW-1:0] well_c(input logic [WordW-1:0] c);
    return c ^ (c >> 11);
  endfunction

  // Value written back at position-1; anew is the word stored at position
  function automatic logic [WordW-1:0] well_z(input logic [WordW-1:0] m,
                                              input logic [WordW-1:0] b,
                                              input logic [WordW-1:0] c,
                                              input logic [WordW-1:0] anew);
    logic [WordW-1:0] d;
    d = anew ^ ((anew << 5) & TemperMask);
    return m ^ b ^ d ^ (m << 2) ^ (b << 18) ^ (c << 28);
  endfunction

endpackage

[rtl/core/well512_random_generator_top.sv]
// WELL512a generator: pool RAM, shared multiplier and the sequencer.
// Raw draw: states RD1 to RD4, WR and OUT from acceptance to result; next request taken back in IDLE.
// Range draw: MUL and ADD come after WR for the multiply and add; empty range: straight to OUT.
// Load: written in IDLE. Reseed: FFIRST, then one FMUL and FWR pair per chain multiply.
// Reset (async, active low): seed back to its default, position zero, then a
// pool fill during which in_stall_o stays high.
`timescale 1ns / 1ps
`include "well512_random_generator_top_defines.svh"

module well512_random_generator_top
  import wrg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [WordW-1:0] range_low_i,
  input  logic signed [WordW-1:0] range_high_i,
  input  logic [PoolAw-1:0]  word_index_i,
  input  logic [WordW-1:0]   word_value_i,
  input  logic [PoolAw-1:0]  new_position_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   raw_word_o,
  output logic signed [WordW-1:0] ranged_value_o
);

  wrg_state_e state_q, state_d;

  logic [WordW-1:0]  seed_q;
  logic [PoolAw-1:0] pos_q, pos_d;
  logic [PoolAw-1:0] fill_idx_q, fill_idx_d;
  logic              is_range_q, is_range_d;

  // datapath registers
  logic [WordW-1:0] a_q, a_d, c13_q, c13_d, c9_q, c9_d, m_q, m_d;
  logic [WordW-1:0] word_q, word_d, rng_q, rng_d, lo_q, lo_d;
  logic [SpanW-1:0] span_q, span_d;

  // result register
  logic             out_valid_q;
  logic [WordW-1:0] out_raw_q, out_rng_q;
  logic             out_load;

  // RAM and multiplier hookup
  logic              ram_we;
  logic [PoolAw-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;
  wrg_mul_req_t      mul_req;
  logic [ProdW-1:0]  mul_prod;

  logic             in_acc, load_acc;
  logic [WordW-1:0] b_w, c_w, anew_w, z_w, fill_w, lo_ob, hi_ob;

  wrg_ram #(
    .Width (WordW),
    .Depth (PoolDepth)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wrg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (wrg_req_e'(req_type_i) == REQ_LOAD);

  // recurrence terms from the captured taps
  assign b_w    = well_b(a_q, c13_q);
  assign c_w    = well_c(c9_q);
  assign anew_w = b_w ^ c_w;
  assign z_w    = well_z(m_q, b_w, c_w, anew_w);
  assign fill_w = mul_prod[WordW-1:0] + {{(WordW - PoolAw){1'b0}}, fill_idx_q};

  // offset-binary bounds for the unsigned compare and span
  assign lo_ob = range_low_i ^ SignFlip;
  assign hi_ob = range_high_i ^ SignFlip;

  // Seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FFIRST;
      pos_q      <= '0;
      fill_idx_q <= '0;
      is_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      fill_idx_q <= fill_idx_d;
      is_range_q <= is_range_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    c13_q  <= c13_d;
    c9_q   <= c9_d;
    m_q    <= m_d;
    word_q <= word_d;
    rng_q  <= rng_d;
    lo_q   <= lo_d;
    span_q <= span_d;
  end

  // Sequencer: next state, RAM and multiplier control
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    fill_idx_d = fill_idx_q;
    is_range_d = is_range_q;
    a_d        = a_q;
    c13_d      = c13_q;
    c9_d       = c9_q;
    m_d        = m_q;
    word_d     = word_q;
    rng_d      = rng_q;
    lo_d       = lo_q;
    span_d     = span_q;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = anew_w;
    ram_raddr  = pos_q;
    mul_req    = '0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // read of pool[pos] is already on its way
        if (in_valid_i) begin
          case (wrg_req_e'(req_type_i))
            REQ_RAW: begin
              is_range_d = 1'b0;
              state_d    = ST_RD1;
            end
            REQ_RANGE: begin
              lo_d = range_low_i;
              if (hi_ob < lo_ob) begin
                word_d  = '0;
                rng_d   = range_low_i;
                state_d = ST_OUT;
              end else begin
                is_range_d = 1'b1;
                span_d     = {1'b0, hi_ob} - {1'b0, lo_ob} + SpanW'(1);
                state_d    = ST_RD1;
              end
            end
            REQ_RESEED: begin
              state_d = ST_FFIRST;
            end
            REQ_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = word_index_i;
              ram_wdata = word_value_i;
              pos_d     = new_position_i;
            end
            default: ;
          endcase
        end
      end
      ST_RD1: begin
        a_d       = ram_rdata;
        ram_raddr = pos_q + OffTapA;
        state_d   = ST_RD2;
      end
      ST_RD2: begin
        c13_d     = ram_rdata;
        ram_raddr = pos_q + OffTapB;
        state_d   = ST_RD3;
      end
      ST_RD3: begin
        c9_d      = ram_rdata;
        ram_raddr = pos_q + OffPrev;
        state_d   = ST_RD4;
      end
      ST_RD4: begin
        // previous word arrives; store the new word at position
        m_d       = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = anew_w;
        state_d   = ST_WR;
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q + OffPrev;
        ram_wdata = z_w;
        word_d    = z_w;
        rng_d     = z_w;
        pos_d     = pos_q + OffPrev;
        state_d   = is_range_q ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = word_q;
        mul_req.b  = span_q;
        state_d    = ST_ADD;
      end
      ST_ADD: begin
        rng_d   = lo_q + mul_prod[ProdW-1:WordW];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FFIRST: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = seed_q ^ SeedMix;
        word_d     = seed_q ^ SeedMix;
        fill_idx_d = PoolAw'(1);
        state_d    = ST_FMUL;
      end
      ST_FMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = word_q ^ (word_q >> 30);
        mul_req.b  = {1'b0, ChainMul};
        state_d    = ST_FWR;
      end
      ST_FWR: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx_q;
        ram_wdata = fill_w;
        word_d    = fill_w;
        if (fill_idx_q == PoolLast) begin
          state_d = ST_IDLE;
        end else begin
          fill_idx_d = fill_idx_q + PoolAw'(1);
          state_d    = ST_FMUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register: holds one finished transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_raw_q <= word_q;
      out_rng_q <= rng_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_word_o     = out_raw_q;
  assign ranged_value_o = out_rng_q;

  // Checks
  `WRG_ASSERT(a_pos_change, (pos_q != $past(pos_q)) |-> ($past(state_q) == ST_WR || $past(load_acc)), "position moved outside a draw or load")
  `WRG_ASSERT(a_we_state, ram_we |-> (state_q == ST_RD4 || state_q == ST_WR || state_q == ST_FFIRST || state_q == ST_FWR || state_q == ST_IDLE), "pool write in a read-only state")
  `WRG_ASSERT_NEXT(a_out_load, out_load, out_valid_q && out_raw_q == $past(word_q), "result register not loaded")
  `WRG_ASSERT(a_fill_idx, (state_q == ST_FWR) |-> (fill_idx_q != '0), "fill chain overwrote word zero")

endmodule

[rtl/core/wrg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module wrg_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/wrg_mul.sv]
// Shared 32x33 multiplier with a registered product.
// Depends on wrg_pkg for widths and the request struct.
`timescale 1ns / 1ps

module wrg_mul
  import wrg_pkg::*;
(
  input  logic             clk_i,
  input  wrg_mul_req_t     req_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW:0]   full;
  logic [ProdW-1:0] prod_q;

  // Product fits in 64 bits since the word is below 2^32 and span at most 2^32
  assign full = {{(ProdW + 1 - WordW){1'b0}}, req_i.a}
              * {{(ProdW + 1 - SpanW){1'b0}}, req_i.b};

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= full[ProdW-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

[verif/testbench.sv]
// Self-checking testbench for well512_random_generator_top (WELL512a generator).
// Depends on wrg_pkg and the generator RTL; mirrors the pool, position and seed
// in SystemVerilog and checks every draw under random idling and back-pressure.
`timescale 1ns / 1ps

module testbench;
  import wrg_pkg::*;

  localparam int CycleLimit   = 600_000;
  localparam int SettleCycles = 40;    // covers the reseed and reset fill
  localparam int HoldCycles   = 300;
  localparam logic signed [WordW-1:0] IntMin = {1'b1, {(WordW-1){1'b0}}};
  localparam logic signed [WordW-1:0] IntMax = {1'b0, {(WordW-1){1'b1}}};

  typedef struct {
    logic [WordW-1:0]        raw;
    logic signed [WordW-1:0] ranged;
  } draw_result_t;

  // DUT inputs, known from time zero
  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [WordW-1:0]         cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic [1:0]               req_type_i     = REQ_RAW;
  logic signed [WordW-1:0]  range_low_i    = '0;
  logic signed [WordW-1:0]  range_high_i   = '0;
  logic [PoolAw-1:0]        word_index_i   = '0;
  logic [WordW-1:0]         word_value_i   = '0;
  logic [PoolAw-1:0]        new_position_i = '0;
  logic                     out_stall_i    = 1'b0;

  // DUT outputs
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [WordW-1:0]         raw_word_o;
  logic signed [WordW-1:0]  ranged_value_o;

  // Mirror of the generator state
  logic [WordW-1:0]         pool_mirror [PoolDepth];
  logic [PoolAw-1:0]        pos_mirror;
  logic [WordW-1:0]         seed_mirror;
  draw_result_t             pending_draws [$];

  // Idling controls and bookkeeping
  bit                       tx_idle_on  = 1'b1;
  bit                       rx_idle_on  = 1'b1;
  bit                       long_hold   = 1'b0;
  int                       rx_left     = 0;
  int                       err_count   = 0;
  int unsigned              cycle_count = 0;
  event                     hold_go;

  well512_random_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .word_index_i   (word_index_i),
    .word_value_i   (word_value_i),
    .new_position_i (new_position_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .raw_word_o     (raw_word_o),
    .ranged_value_o (ranged_value_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Generator mirror
  // ---------------------------------------------------------------------------

  // Seed chain: w0 = seed ^ mix, wi = mul * (w(i-1) ^ (w(i-1) >> 30)) + i
  function automatic void refill_pool(input logic [WordW-1:0] seed);
    logic [WordW-1:0] prev;
    pool_mirror[0] = seed ^ SeedMix;
    for (int i = 1; i < PoolDepth; i++) begin
      prev = pool_mirror[i-1];
      pool_mirror[i] = ChainMul * (prev ^ (prev >> 30)) + WordW'(i);
    end
  endfunction

  // One WELL512a step; returns the word now at the new position
  function automatic logic [WordW-1:0] advance_pool();
    logic [WordW-1:0]  a, b, c, d, m;
    logic [PoolAw-1:0] tap;
    a   = pool_mirror[pos_mirror];
    tap = pos_mirror + OffTapA;
    c   = pool_mirror[tap];
    b   = a ^ c ^ (a << 16) ^ (c << 15);
    tap = pos_mirror + OffTapB;
    c   = pool_mirror[tap];
    c   = c ^ (c >> 11);
    a   = b ^ c;
    pool_mirror[pos_mirror] = a;
    d   = a ^ ((a << 5) & TemperMask);
    pos_mirror = pos_mirror + OffPrev;
    m   = pool_mirror[pos_mirror];
    pool_mirror[pos_mirror] = m ^ b ^ d ^ (m << 2) ^ (b << 18) ^ (c << 28);
    return pool_mirror[pos_mirror];
  endfunction

  // Apply one accepted request to the mirror, queue the draw it yields
  function automatic void advance_generator(input wrg_req_e kind,
                                            input logic signed [WordW-1:0] lo,
                                            input logic signed [WordW-1:0] hi,
                                            input logic [PoolAw-1:0] idx,
                                            input logic [WordW-1:0] val,
                                            input logic [PoolAw-1:0] pos);
    logic [WordW-1:0]       w, lo_ob, hi_ob;
    logic [SpanW-1:0]       span;
    logic [WordW+SpanW-1:0] prod;
    case (kind)
      REQ_RAW: begin
        w = advance_pool();
        pending_draws.push_back('{raw: w, ranged: w});
      end
      REQ_RANGE: begin
        // offset-binary so the signed bounds compare as unsigned
        lo_ob = lo ^ SignFlip;
        hi_ob = hi ^ SignFlip;
        if (hi_ob < lo_ob) begin
          pending_draws.push_back('{raw: '0, ranged: lo});
        end else begin
          span = {1'b0, hi_ob - lo_ob} + SpanW'(1);
          w    = advance_pool();
          prod = {{SpanW{1'b0}}, w} * {{WordW{1'b0}}, span};
          pending_draws.push_back('{raw: w, ranged: lo + prod[ProdW-1:WordW]});
        end
      end
      REQ_RESEED: refill_pool(seed_mirror);
      default: begin
        pool_mirror[idx] = val;
        pos_mirror = pos;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  // Long hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk_i);
      long_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      long_hold <= 1'b0;
    end
  end

  // Per-transaction random stall on the result channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_left = 0;
    end else if (out_valid_o && !out_stall_i) begin
      rx_left = rx_idle_on ? $urandom_range(0, 10) : 0;
    end else if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end
    out_stall_i <= long_hold || (rx_left > 0);
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // Compare each taken result with the oldest queued draw
  always @(posedge clk_i) begin : check_results
    draw_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("result with no draw pending");
      end else begin
        want = pending_draws.pop_front();
        if (raw_word_o !== want.raw)
          report_mismatch($sformatf("raw_word got %h want %h", raw_word_o, want.raw));
        if (ranged_value_o !== want.ranged)
          report_mismatch($sformatf("ranged_value got %h want %h",
                                    ranged_value_o, want.ranged));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap and hold it until accepted
  task automatic send_req(input wrg_req_e kind,
                          input logic signed [WordW-1:0] lo,
                          input logic signed [WordW-1:0] hi,
                          input logic [PoolAw-1:0] idx,
                          input logic [WordW-1:0] val,
                          input logic [PoolAw-1:0] pos);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    range_low_i    <= lo;
    range_high_i   <= hi;
    word_index_i   <= idx;
    word_value_i   <= val;
    new_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    advance_generator(kind, lo, hi, idx, val, pos);
  endtask

  // Mostly draws, with loads and reseeds mixed in; bounds favor edge shapes
  task automatic send_random_request();
    logic signed [WordW-1:0] lo, hi;
    int unsigned             sel;
    wrg_req_e                kind;
    lo  = $urandom;
    hi  = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      kind = REQ_RAW;
    end else if (sel < 85) begin
      kind = REQ_RANGE;
      case ($urandom_range(0, 4))
        1: hi = lo + WordW'($urandom_range(0, 255));
        2: begin
          lo = IntMin + WordW'($urandom_range(0, 3));
          hi = IntMax - WordW'($urandom_range(0, 3));
        end
        3: hi = lo;
        4: hi = lo - 1;
        default: ;  // arbitrary bounds, often reversed
      endcase
    end else if (sel < 93) begin
      kind = REQ_LOAD;
    end else begin
      kind = REQ_RESEED;
    end
    send_req(kind, lo, hi, PoolAw'($urandom), $urandom, PoolAw'($urandom));
  endtask

  // Drop valid, drain all draws and let a reseed or load finish
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [WordW-1:0] seed);
    settle_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_mirror = seed;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every request kind, empty and full intervals
  task automatic test_directed_cases();
    send_req(REQ_RAW,    '0, '0, '0, '0, '0);
    send_req(REQ_RAW,    IntMax, IntMin, '1, '1, '1);
    send_req(REQ_RANGE,  IntMin, IntMax, '0, '0, '0);     // full 2^32 span
    send_req(REQ_RANGE,  IntMin, IntMax, '0, '0, '0);
    send_req(REQ_RANGE,  '0, '0, '0, '0, '0);             // single point
    send_req(REQ_RANGE,  IntMax, IntMax, '0, '0, '0);
    send_req(REQ_RANGE,  IntMin, IntMin, '0, '0, '0);
    send_req(REQ_RANGE,  32'sd5, 32'sd4, '0, '0, '0);     // empty interval
    send_req(REQ_RANGE,  IntMax, IntMin, '0, '0, '0);     // empty, widest reversal
    send_req(REQ_RANGE,  -32'sd100, -32'sd1, '0, '0, '0);
    send_req(REQ_RANGE,  IntMin, -32'sd1, '0, '0, '0);
    send_req(REQ_RANGE,  '0, IntMax, '0, '0, '0);
    send_req(REQ_LOAD,   '0, '0, '0, '0, '0);
    send_req(REQ_RAW,    '0, '0, '0, '0, '0);             // position wraps below zero
    send_req(REQ_LOAD,   '1, '1, '1, '1, '1);
    send_req(REQ_RAW,    '0, '0, '0, '0, '0);
    send_req(REQ_RANGE,  -32'sd7, 32'sd7, '0, '0, '0);
    send_req(REQ_RESEED, '0, '0, '0, '0, '0);             // position kept
    send_req(REQ_RAW,    '0, '0, '0, '0, '0);
    send_req(REQ_LOAD,   '0, '0, PoolAw'(5), 32'hA5A5_5A5A, PoolAw'(7));
    send_req(REQ_RAW,    '0, '0, '0, '0, '0);
    send_req(REQ_RANGE,  32'sd1, 32'sd1000, '0, '0, '0);
  endtask

  // Reseed under several seeds, the extremes and the reset value among them
  task automatic test_seed_settings();
    logic [WordW-1:0] seeds [4];
    seeds = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, SeedReset};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_req(REQ_RESEED, '0, '0, '0, '0, '0);
      repeat (12) send_random_request();
    end
  endtask

  // Receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    -> hold_go;
    repeat (40) send_random_request();
  endtask

  // Bulk random traffic, rotating idling modes, new seed every few chunks
  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 16; chunk++) begin
      if (chunk % 4 == 3) write_seed($urandom);
      tx_idle_on = (chunk % 4 == 0) || (chunk % 4 == 2);
      rx_idle_on <= (chunk % 4 == 0) || (chunk % 4 == 3);
      repeat (100) send_random_request();
    end
  endtask

  initial begin
    seed_mirror = SeedReset;
    pos_mirror  = '0;
    refill_pool(SeedReset);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_seed_settings();
    test_backpressure();
    test_random_traffic();
    settle_block();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
